// ===== design/hlw_pkg.sv =====
package hlw_pkg;

  localparam int unsigned TIME_BITS  = 48;
  localparam int unsigned EPOCH_BITS = 32;
  localparam int unsigned CFG_BITS   = 32;
  localparam int unsigned CNT_BITS   = 16;

  localparam logic [CNT_BITS-1:0] CNT_MAX = '1;

  typedef enum logic [1:0] {
    OP_START = 2'd0,
    OP_STAMP = 2'd1,
    OP_TICK  = 2'd2,
    OP_NONE  = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    VERD_NOTHING   = 3'd0,
    VERD_FIRST     = 3'd1,
    VERD_SILENT    = 3'd2,
    VERD_STILL     = 3'd3,
    VERD_RECOVERED = 3'd4,
    VERD_NEVER     = 3'd5
  } verdict_e;

  typedef enum logic [1:0] {
    CFG_SILENT_AFTER = 2'd0,
    CFG_GRACE        = 2'd1,
    CFG_REPEAT       = 2'd2,
    CFG_FAIL_LIMIT   = 2'd3
  } cfg_idx_e;

  localparam logic [CFG_BITS-1:0] SILENT_AFTER_RST = 32'd5000;
  localparam logic [CFG_BITS-1:0] GRACE_RST        = 32'd30000;
  localparam logic [CFG_BITS-1:0] REPEAT_RST       = 32'd10000;
  localparam logic [CNT_BITS-1:0] FAIL_LIMIT_RST   = 16'd3;

  typedef struct packed {
    op_e                           operation;
    logic [TIME_BITS-1:0]          now_ms;
    logic signed [EPOCH_BITS-1:0]  epoch;
    logic                          probe_done;
    logic                          probe_pass;
  } in_item_t;

  typedef struct packed {
    verdict_e                      verdict;
    logic [TIME_BITS-1:0]          quiet_time;
    logic                          has_stamp;
    logic [CNT_BITS-1:0]           fail_streak;
    logic                          loss_event;
    logic                          regain_event;
    logic signed [EPOCH_BITS-1:0]  last_epoch;
  } out_item_t;

  typedef struct packed {
    logic [CFG_BITS-1:0] stamp_timeout;
    logic [CFG_BITS-1:0] arm_timeout;
    logic [CFG_BITS-1:0] repeat_period;
    logic [CNT_BITS-1:0] raster_failure_limit;
  } cfg_t;

  typedef struct packed {
    logic signed [EPOCH_BITS-1:0] armed_epoch;
    logic                         watching;
    logic [TIME_BITS-1:0]         epoch_start_time;
    logic [TIME_BITS-1:0]         last_stamp_time;
    logic [TIME_BITS-1:0]         last_report_time;
    logic                         stamped;
    logic                         silent;
    logic signed [EPOCH_BITS-1:0] recorded_epoch;
    logic [CNT_BITS-1:0]          failure_count;
    logic                         raster_loss;
  } wd_state_t;

endpackage

// ===== design/hlw_step.sv =====
module hlw_step import hlw_pkg::*; (
  input  in_item_t  item_i,
  input  wd_state_t state_i,
  input  cfg_t      cfg_i,
  output wd_state_t state_o,
  output out_item_t result_o
);

  logic [TIME_BITS-1:0] ref_time;
  logic [TIME_BITS-1:0] silence;
  logic [TIME_BITS-1:0] threshold;
  logic [TIME_BITS-1:0] since_report;
  logic                 repeat_due;
  logic                 ignore_stamp;
  logic [CNT_BITS-1:0]  fail_inc;

  always_comb begin
    ref_time     = state_i.stamped ? state_i.last_stamp_time : state_i.epoch_start_time;
    silence      = (item_i.now_ms > ref_time) ? item_i.now_ms - ref_time : '0;
    threshold    = state_i.stamped ? TIME_BITS'(cfg_i.stamp_timeout)
                                   : TIME_BITS'(cfg_i.arm_timeout);
    since_report = item_i.now_ms - state_i.last_report_time;
    repeat_due   = (item_i.now_ms < state_i.last_report_time) ||
                   (since_report >= TIME_BITS'(cfg_i.repeat_period));
    // both epochs known and different
    ignore_stamp = !item_i.epoch[EPOCH_BITS-1] && !state_i.armed_epoch[EPOCH_BITS-1] &&
                   (item_i.epoch != state_i.armed_epoch);
    fail_inc     = (state_i.failure_count == CNT_MAX) ? CNT_MAX
                                                      : state_i.failure_count + 1'b1;
  end

  always_comb begin
    state_o  = state_i;
    // default: snapshot of the current state
    result_o.verdict      = VERD_NOTHING;
    result_o.quiet_time   = silence;
    result_o.has_stamp    = state_i.stamped;
    result_o.fail_streak  = state_i.failure_count;
    result_o.loss_event   = 1'b0;
    result_o.regain_event = 1'b0;
    result_o.last_epoch   = state_i.recorded_epoch;

    case (item_i.operation)
      OP_START: begin
        state_o.armed_epoch      = item_i.epoch;
        state_o.watching         = 1'b1;
        state_o.epoch_start_time = item_i.now_ms;
        state_o.last_stamp_time  = '0;
        state_o.last_report_time = '0;
        state_o.stamped          = 1'b0;
        state_o.silent           = 1'b0;
        state_o.recorded_epoch   = '1;
        state_o.failure_count    = '0;
        state_o.raster_loss      = 1'b0;
        result_o.quiet_time      = '0;
        result_o.has_stamp       = 1'b0;
        result_o.fail_streak     = '0;
        result_o.last_epoch      = '1;
      end
      OP_STAMP: begin
        if (ignore_stamp) begin
          result_o.last_epoch = item_i.epoch;
        end else begin
          state_o.recorded_epoch   = item_i.epoch;
          state_o.last_stamp_time  = item_i.now_ms;
          state_o.stamped          = 1'b1;
          state_o.silent           = 1'b0;
          state_o.last_report_time = '0;
          if (!state_i.stamped) begin
            result_o.verdict = VERD_FIRST;
          end else if (state_i.silent) begin
            result_o.verdict = VERD_RECOVERED;
          end
          if (item_i.probe_done) begin
            if (item_i.probe_pass) begin
              result_o.regain_event = state_i.raster_loss;
              state_o.failure_count = '0;
              state_o.raster_loss   = 1'b0;
            end else begin
              state_o.failure_count = fail_inc;
              if (!state_i.raster_loss && (cfg_i.raster_failure_limit != '0) &&
                  (fail_inc >= cfg_i.raster_failure_limit)) begin
                state_o.raster_loss = 1'b1;
                result_o.loss_event = 1'b1;
              end
            end
          end
          result_o.has_stamp   = 1'b1;
          result_o.fail_streak = state_o.failure_count;
          result_o.last_epoch  = item_i.epoch;
        end
      end
      OP_TICK: begin
        if (!state_i.watching) begin
          result_o.quiet_time  = '0;
          result_o.has_stamp   = 1'b0;
          result_o.fail_streak = '0;
          result_o.last_epoch  = '1;
        end else if (silence > threshold) begin
          if (!state_i.silent) begin
            state_o.silent           = 1'b1;
            state_o.last_report_time = item_i.now_ms;
            result_o.verdict         = state_i.stamped ? VERD_SILENT : VERD_NEVER;
          end else if (repeat_due) begin
            state_o.last_report_time = item_i.now_ms;
            result_o.verdict         = VERD_STILL;
          end
        end
      end
      default: begin
        // unused code: snapshot only
      end
    endcase
  end

endmodule

// ===== design/heartbeat_liveness_watchdog_core.sv =====
// Heartbeat watchdog core. Stage 1 holds the registered input item; stage 2, the
// result register, is loaded from it when free or being drained. Throughput: one
// item per cycle while the result side does not stall; the state update is a single
// pass of compares and 48-bit subtractions between the input register and the
// result register. Reset: asynchronous, active low; watchdog state and config
// registers return to defaults, both pipeline stages empty. No clearing pass.
module heartbeat_liveness_watchdog_core import hlw_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  // input channel
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  in_item_t            in_data_i,
  // result channel
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output out_item_t           out_data_o,
  // configuration writes
  input  logic                cfg_we_i,
  input  logic [1:0]          cfg_idx_i,
  input  logic [CFG_BITS-1:0] cfg_wdata_i
);

  // stage 1: registered input item
  logic      s1_valid_q;
  in_item_t  s1_item_q;
  // stage 2: result register
  logic      out_valid_q;
  out_item_t out_item_q;

  cfg_t      cfg_q;
  wd_state_t state_q, state_d;
  out_item_t result_d;

  logic      s1_advance;
  logic      in_xfer;

  // stage 1 moves on when the result register is free or being drained
  assign s1_advance = !out_valid_q || out_ready_i;
  assign in_ready_o = !s1_valid_q || s1_advance;
  assign in_xfer    = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      s1_item_q <= in_data_i;
    end
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.stamp_timeout        <= SILENT_AFTER_RST;
      cfg_q.arm_timeout          <= GRACE_RST;
      cfg_q.repeat_period        <= REPEAT_RST;
      cfg_q.raster_failure_limit <= FAIL_LIMIT_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_SILENT_AFTER: cfg_q.stamp_timeout        <= cfg_wdata_i;
        CFG_GRACE:        cfg_q.arm_timeout          <= cfg_wdata_i;
        CFG_REPEAT:       cfg_q.repeat_period        <= cfg_wdata_i;
        CFG_FAIL_LIMIT:   cfg_q.raster_failure_limit <= cfg_wdata_i[CNT_BITS-1:0];
        default: ;
      endcase
    end
  end

  // one full step per item, state and result settle in the same pass
  hlw_step u_step (
    .item_i   (s1_item_q),
    .state_i  (state_q),
    .cfg_i    (cfg_q),
    .state_o  (state_d),
    .result_o (result_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.armed_epoch      <= '1;
      state_q.watching         <= 1'b0;
      state_q.epoch_start_time <= '0;
      state_q.last_stamp_time  <= '0;
      state_q.last_report_time <= '0;
      state_q.stamped          <= 1'b0;
      state_q.silent           <= 1'b0;
      state_q.recorded_epoch   <= '1;
      state_q.failure_count    <= '0;
      state_q.raster_loss      <= 1'b0;
    end else if (s1_valid_q && s1_advance) begin
      state_q <= state_d;
    end
  end

  // result register; holds while the consumer stalls
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_advance) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_valid_q && s1_advance) begin
      out_item_q <= result_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_item_q;

endmodule

// ===== design/hlw_checker.sv =====
module hlw_checker import hlw_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_ready_o,
  input logic      out_valid_o,
  input logic      out_ready_i,
  input out_item_t out_data_o
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result changed while stalled");

  // input side only backs up when the result register is full and stalled
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input stalled without output backpressure");

  // loss and recovery are never reported by the same stamp
  a_raster: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(out_data_o.loss_event && out_data_o.regain_event))
    else $error("raster lost and recovered together");

  // verdicts agree with the stamped flag
  a_stamped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.verdict == VERD_FIRST || out_data_o.verdict == VERD_SILENT ||
                    out_data_o.verdict == VERD_RECOVERED) |-> out_data_o.has_stamp)
    else $error("stamp verdict without stamp");

  a_never: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.verdict == VERD_NEVER |-> !out_data_o.has_stamp)
    else $error("never-arrived after a stamp");

endmodule

bind heartbeat_liveness_watchdog_core hlw_checker u_hlw_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);

// ===== tb/hlw_liveness_checker.sv =====
`timescale 1ns / 100ps

// Watches both channels and the register port, predicts every result and
// compares it against what the core delivers.
module hlw_liveness_checker import hlw_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_ready_i,
  input  in_item_t            in_data_i,
  input  logic                out_valid_i,
  input  logic                out_ready_i,
  input  out_item_t           out_data_i,
  input  logic                cfg_we_i,
  input  logic [1:0]          cfg_idx_i,
  input  logic [CFG_BITS-1:0] cfg_wdata_i,
  input  logic                run_over_i,
  output int                  errors_o,
  output int                  pending_o,
  output int                  checked_o,
  output int                  alerts_o,
  output int                  losses_o
);

  wd_state_t wd;
  cfg_t      cfg;
  out_item_t awaited_results[$];
  logic      leftovers_checked = 1'b0;

  task automatic report_mismatch(input string what, input logic [63:0] want,
                                 input logic [63:0] seen);
    errors_o++;
    if (errors_o <= 40)
      $display("%0t: %s mismatch, expected %0h got %0h", $time, what, want, seen);
  endtask

  // time since the last stamp, or since arming when none yet; never negative
  function automatic logic [TIME_BITS-1:0] quiet_span(logic [TIME_BITS-1:0] now);
    logic [TIME_BITS-1:0] anchor;
    anchor = wd.stamped ? wd.last_stamp_time : wd.epoch_start_time;
    return (now > anchor) ? now - anchor : '0;
  endfunction

  function automatic out_item_t snapshot(logic [TIME_BITS-1:0] now,
                                         logic signed [EPOCH_BITS-1:0] ep);
    out_item_t r;
    r             = '0;
    r.verdict     = VERD_NOTHING;
    r.quiet_time  = quiet_span(now);
    r.has_stamp   = wd.stamped;
    r.fail_streak = wd.failure_count;
    r.last_epoch  = ep;
    return r;
  endfunction

  task automatic step_watchdog(input in_item_t it, output out_item_t res);
    logic [TIME_BITS-1:0] span;
    logic [TIME_BITS-1:0] limit_t;
    logic                 first_stamp;
    logic                 was_silent;
    logic                 lost;
    logic                 recov;
    case (it.operation)
      OP_START: begin
        wd                  = '0;
        wd.armed_epoch      = it.epoch;
        wd.watching         = 1'b1;
        wd.epoch_start_time = it.now_ms;
        wd.recorded_epoch   = '1;
        res = snapshot(it.now_ms, wd.recorded_epoch);
      end
      OP_STAMP: begin
        // only two known, different generations make a stamp foreign
        if (!it.epoch[EPOCH_BITS-1] && !wd.armed_epoch[EPOCH_BITS-1] &&
            it.epoch != wd.armed_epoch) begin
          res = snapshot(it.now_ms, it.epoch);
        end else begin
          first_stamp         = !wd.stamped;
          was_silent          = wd.silent;
          span                = quiet_span(it.now_ms);
          wd.recorded_epoch   = it.epoch;
          wd.last_stamp_time  = it.now_ms;
          wd.stamped          = 1'b1;
          wd.silent           = 1'b0;
          wd.last_report_time = '0;
          lost  = 1'b0;
          recov = 1'b0;
          if (it.probe_done) begin
            if (it.probe_pass) begin
              recov            = wd.raster_loss;
              wd.failure_count = '0;
              wd.raster_loss   = 1'b0;
            end else begin
              if (wd.failure_count != CNT_MAX) wd.failure_count++;
              if (!wd.raster_loss && cfg.raster_failure_limit != '0 &&
                  wd.failure_count >= cfg.raster_failure_limit) begin
                wd.raster_loss = 1'b1;
                lost           = 1'b1;
              end
            end
          end
          res = snapshot(it.now_ms, wd.recorded_epoch);
          if (first_stamp) res.verdict = VERD_FIRST;
          else if (was_silent) res.verdict = VERD_RECOVERED;
          res.quiet_time   = span;
          res.loss_event   = lost;
          res.regain_event = recov;
        end
      end
      OP_TICK: begin
        if (!wd.watching) begin
          res            = '0;
          res.last_epoch = '1;
        end else begin
          span    = quiet_span(it.now_ms);
          limit_t = wd.stamped ? TIME_BITS'(cfg.stamp_timeout)
                               : TIME_BITS'(cfg.arm_timeout);
          res     = snapshot(it.now_ms, wd.recorded_epoch);
          if (span > limit_t) begin
            if (!wd.silent) begin
              wd.silent           = 1'b1;
              wd.last_report_time = it.now_ms;
              if (wd.stamped) res.verdict = VERD_SILENT;
              else res.verdict = VERD_NEVER;
            end else if (it.now_ms < wd.last_report_time ||
                         it.now_ms - wd.last_report_time >=
                         TIME_BITS'(cfg.repeat_period)) begin
              wd.last_report_time = it.now_ms;
              res.verdict         = VERD_STILL;
            end
          end
        end
      end
      default: res = snapshot(it.now_ms, wd.recorded_epoch);
    endcase
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : track
    out_item_t want;
    out_item_t got;
    if (!rst_ni) begin
      wd                       = '0;
      wd.armed_epoch           = '1;
      wd.recorded_epoch        = '1;
      cfg.stamp_timeout        = SILENT_AFTER_RST;
      cfg.arm_timeout          = GRACE_RST;
      cfg.repeat_period        = REPEAT_RST;
      cfg.raster_failure_limit = FAIL_LIMIT_RST;
      awaited_results.delete();
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_idx_i))
          CFG_SILENT_AFTER: cfg.stamp_timeout        = cfg_wdata_i;
          CFG_GRACE:        cfg.arm_timeout          = cfg_wdata_i;
          CFG_REPEAT:       cfg.repeat_period        = cfg_wdata_i;
          CFG_FAIL_LIMIT:   cfg.raster_failure_limit = cfg_wdata_i[CNT_BITS-1:0];
          default: ;
        endcase
      end
      if (out_valid_i && out_ready_i) begin
        got = out_data_i;
        if (awaited_results.size() == 0) begin
          report_mismatch("unexpected result, verdict", '0, 64'(got.verdict));
        end else begin
          want = awaited_results.pop_front();
          checked_o++;
          if (got.verdict != want.verdict)
            report_mismatch("verdict", 64'(want.verdict), 64'(got.verdict));
          if (got.quiet_time != want.quiet_time)
            report_mismatch("quiet_time", 64'(want.quiet_time), 64'(got.quiet_time));
          if (got.has_stamp != want.has_stamp)
            report_mismatch("has_stamp", 64'(want.has_stamp), 64'(got.has_stamp));
          if (got.fail_streak != want.fail_streak)
            report_mismatch("fail_streak", 64'(want.fail_streak),
                            64'(got.fail_streak));
          if (got.loss_event != want.loss_event)
            report_mismatch("loss_event", 64'(want.loss_event), 64'(got.loss_event));
          if (got.regain_event != want.regain_event)
            report_mismatch("regain_event", 64'(want.regain_event),
                            64'(got.regain_event));
          if (got.last_epoch != want.last_epoch)
            report_mismatch("last_epoch", 64'(want.last_epoch), 64'(got.last_epoch));
          if (want.verdict != VERD_NOTHING) alerts_o++;
          if (want.loss_event) losses_o++;
        end
      end
      if (in_valid_i && in_ready_i) begin
        step_watchdog(in_data_i, want);
        awaited_results.push_back(want);
      end
      if (run_over_i && !leftovers_checked) begin
        leftovers_checked = 1'b1;
        if (awaited_results.size() != 0)
          report_mismatch("results never delivered, count", 64'(awaited_results.size()),
                          '0);
      end
    end
    pending_o = awaited_results.size();
  end

endmodule

// ===== tb/heartbeat_liveness_watchdog_core_test.sv =====
`timescale 1ns / 100ps

// Stimulus and verdict for the heartbeat watchdog core. The checker beside the
// core does all prediction and comparison; this module only feeds transfers,
// writes registers between phases and throttles the result side.
module heartbeat_liveness_watchdog_core_test;
  import hlw_pkg::*;

  logic                clk;
  logic                rst_n     = 1'b0;
  logic                in_valid  = 1'b0;
  logic                in_ready;
  in_item_t            in_data   = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  out_item_t           out_data;
  logic                cfg_we    = 1'b0;
  logic [1:0]          cfg_idx   = '0;
  logic [CFG_BITS-1:0] cfg_wdata = '0;
  logic                run_over  = 1'b0;

  int errors, pending, checked, alerts, losses;

  // stimulus-side copy of the registers, used to aim timestamps at thresholds
  logic [CFG_BITS-1:0] quiet_limit = SILENT_AFTER_RST;
  logic [CFG_BITS-1:0] grace_limit = GRACE_RST;
  logic [CFG_BITS-1:0] repeat_gap  = REPEAT_RST;

  logic [TIME_BITS-1:0]         cur_t;
  logic signed [EPOCH_BITS-1:0] cur_epoch;
  int sent_count     = 0;
  int burst_left     = 0;
  int settings_count = 1;
  logic held_off     = 1'b0;

  heartbeat_liveness_watchdog_core dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata)
  );

  hlw_liveness_checker watch_chk (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_i  (in_ready),
    .in_data_i   (in_data),
    .out_valid_i (out_valid),
    .out_ready_i (out_ready),
    .out_data_i  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .run_over_i  (run_over),
    .errors_o    (errors),
    .pending_o   (pending),
    .checked_o   (checked),
    .alerts_o    (alerts),
    .losses_o    (losses)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // backstop: far beyond the slowest legal run
  initial begin
    #100_000_000;
    $display("FAILURE");
    $finish;
  end

  // mostly back-to-back, some short gaps, a few long ones
  function automatic int pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic in_item_t mk(op_e op, logic [TIME_BITS-1:0] now,
                                  logic signed [EPOCH_BITS-1:0] ep,
                                  logic probed, logic ok);
    in_item_t it;
    it.operation  = op;
    it.now_ms     = now;
    it.epoch      = ep;
    it.probe_done = probed;
    it.probe_pass = ok;
    return it;
  endfunction

  function automatic logic signed [EPOCH_BITS-1:0] pick_epoch();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return $urandom_range(0, 15);
    if (r < 75) return $urandom() & 32'h7FFF_FFFF;
    if (r < 85) return '1;                                // unknown generation
    if (r < 92) return $urandom() | 32'h8000_0000;
    if (r < 96) return 32'h7FFF_FFFF;
    return '0;
  endfunction

  // how far the clock moves before the next event; aims near the thresholds
  function automatic logic [TIME_BITS-1:0] time_advance();
    logic [TIME_BITS-1:0] nudge;
    nudge = TIME_BITS'($urandom_range(0, 2));
    case ($urandom_range(0, 19))
      0, 1:          return '0;
      2, 3, 4, 5, 6: return TIME_BITS'($urandom_range(0, quiet_limit));
      7, 8:          return TIME_BITS'(quiet_limit) + nudge - 1;
      9, 10:         return TIME_BITS'(grace_limit) + nudge - 1;
      11, 12:        return TIME_BITS'(repeat_gap) + nudge - 1;
      13, 14, 15:    return TIME_BITS'($urandom_range(0, repeat_gap));
      16, 17:        return TIME_BITS'($urandom_range(0, 200));
      18:            return TIME_BITS'($urandom());
      default:       return TIME_BITS'({$urandom(), $urandom()});
    endcase
  endfunction

  // mostly well-formed epochs: arm, stamps of the armed generation, ticks;
  // the rest foreign stamps, backwards time and unused op codes
  task automatic make_random_item(output in_item_t it);
    int unsigned pick;
    int unsigned r;
    pick = $urandom_range(0, 99);
    cur_t = cur_t + time_advance();
    it = mk(OP_TICK, cur_t, cur_epoch, $urandom_range(0, 99) < 70,
            1'($urandom_range(0, 1)));
    if (pick < 5) begin
      it.operation = OP_START;
      cur_epoch    = pick_epoch();
      it.epoch     = cur_epoch;
    end else if (pick < 55) begin
      it.operation = OP_STAMP;
      r = $urandom_range(0, 99);
      if (r >= 94) it.epoch = $urandom();
      else if (r >= 88) it.epoch = cur_epoch + 1;
      else if (r >= 80) it.epoch = '1;
    end else if (pick < 95) begin
      it.epoch = $urandom();                     // ignored on a tick
    end else if (pick < 98) begin
      it = mk(OP_NONE, TIME_BITS'({$urandom(), $urandom()}), $urandom(),
              1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    end else begin
      if ($urandom_range(0, 1)) it.operation = OP_STAMP;
      it.now_ms = cur_t - TIME_BITS'($urandom_range(1, 100000));
    end
  endtask

  // one transfer; valid stays up with the payload until the core takes it
  task automatic send_item(input in_item_t it);
    int gap;
    if (burst_left > 0) begin
      gap = 0;
      burst_left--;
    end else begin
      gap = pick_gap();
      if ($urandom_range(0, 99) < 3) burst_left = $urandom_range(30, 80);
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (!in_ready);
    sent_count++;
  endtask

  // drop valid and let every expected result drain before touching registers
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic apply_settings(input logic [CFG_BITS-1:0] quiet, grace, rpt,
                                input logic [CNT_BITS-1:0] fails);
    cfg_we    <= 1'b1;
    cfg_idx   <= CFG_SILENT_AFTER;
    cfg_wdata <= quiet;
    @(posedge clk);
    cfg_idx   <= CFG_GRACE;
    cfg_wdata <= grace;
    @(posedge clk);
    cfg_idx   <= CFG_REPEAT;
    cfg_wdata <= rpt;
    @(posedge clk);
    cfg_idx   <= CFG_FAIL_LIMIT;
    cfg_wdata <= CFG_BITS'(fails);
    @(posedge clk);
    cfg_we      <= 1'b0;
    quiet_limit  = quiet;
    grace_limit  = grace;
    repeat_gap   = rpt;
    settings_count++;
  endtask

  task automatic run_phase(input logic [CFG_BITS-1:0] quiet, grace, rpt,
                           input logic [CNT_BITS-1:0] fails, input int n_items);
    in_item_t it;
    settle();
    apply_settings(quiet, grace, rpt, fails);
    repeat (n_items) begin
      make_random_item(it);
      send_item(it);
    end
  endtask

  // result side: random stalls, plus one long hold-off once traffic is going
  initial begin : result_side
    int busy;
    int gap;
    wait (rst_n);
    @(posedge clk);
    forever begin
      if (!held_off && sent_count >= 400) begin
        held_off = 1'b1;
        out_ready <= 1'b0;
        repeat (150) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        busy = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                           : $urandom_range(1, 40);
        repeat (busy) @(posedge clk);
        gap = pick_gap();
        if (gap > 0) begin
          out_ready <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
    end
  end

  initial begin : source_side
    int waited;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed pass at the reset register values (5000 / 30000 / 10000 / 3)
    send_item(mk(OP_TICK,  48'd100, '1, 1'b0, 1'b0));   // not armed yet: zeros, last_epoch all ones
    send_item(mk(OP_STAMP, 48'd200, 32'sd7, 1'b1, 1'b0)); // stamp before any start
    send_item(mk(OP_TICK,  48'd300, '1, 1'b0, 1'b0));   // still not watching
    send_item(mk(OP_NONE,  48'd400, 32'sd3, 1'b1, 1'b1));
    send_item(mk(OP_START, 48'd1000, 32'sd5, 1'b0, 1'b0));
    send_item(mk(OP_TICK,  48'd31000, '0, 1'b0, 1'b0));  // exactly at grace
    send_item(mk(OP_TICK,  48'd31001, '0, 1'b0, 1'b0));  // never arrived
    send_item(mk(OP_TICK,  48'd31002, '0, 1'b0, 1'b0));
    send_item(mk(OP_TICK,  48'd41001, '0, 1'b0, 1'b0));  // repeat period met
    send_item(mk(OP_TICK,  48'd41000, '0, 1'b0, 1'b0));  // behind last report
    send_item(mk(OP_STAMP, 48'd41500, 32'sd9, 1'b1, 1'b0)); // foreign generation
    send_item(mk(OP_STAMP, 48'd42000, 32'sd5, 1'b1, 1'b0));
    send_item(mk(OP_STAMP, 48'd43000, '1, 1'b1, 1'b0));    // unknown generation
    send_item(mk(OP_STAMP, 48'd44000, 32'sd5, 1'b1, 1'b0)); // loss declared
    send_item(mk(OP_STAMP, 48'd44500, 32'sd5, 1'b1, 1'b0));
    send_item(mk(OP_STAMP, 48'd45000, 32'sd5, 1'b1, 1'b1)); // raster recovers
    send_item(mk(OP_STAMP, 48'd45500, 32'sd5, 1'b0, 1'b1)); // ok without probe
    send_item(mk(OP_TICK,  48'd50501, '0, 1'b0, 1'b0));     // silent
    send_item(mk(OP_STAMP, 48'd60000, 32'sd5, 1'b0, 1'b0)); // recovered
    send_item(mk(OP_STAMP, 48'd50000, 32'sd5, 1'b0, 1'b0)); // time went back
    send_item(mk(OP_START, 48'hFFFF_FFFF_FFF0, '1, 1'b0, 1'b0));
    send_item(mk(OP_STAMP, 48'hFFFF_FFFF_FFF5, 32'sd123456, 1'b1, 1'b0));
    send_item(mk(OP_TICK,  '1, '0, 1'b0, 1'b0));
    send_item(mk(OP_START, '0, 32'sh7FFF_FFFF, 1'b0, 1'b0));
    send_item(mk(OP_NONE,  '1, '1, 1'b1, 1'b1));

    cur_t     = '0;
    cur_epoch = 32'sh7FFF_FFFF;

    run_phase(SILENT_AFTER_RST, GRACE_RST, REPEAT_RST, FAIL_LIMIT_RST, 280);
    run_phase('0, '0, '0, '0, 250);
    run_phase('1, '1, '1, '1, 200);
    run_phase(32'd10, 32'd20, 32'd5, 16'd1, 300);
    run_phase($urandom_range(0, 3000), $urandom_range(0, 6000),
              $urandom_range(0, 4000), 16'($urandom_range(1, 5)), 300);
    run_phase(32'd100, 32'd0, '1, 16'd2, 300);

    // long failing probe run: loss at a high limit, the count keeps climbing,
    // then one good probe clears it
    settle();
    apply_settings(32'd1000, 32'd2000, 32'd500, 16'd20);
    send_item(mk(OP_START, cur_t, 32'sd3, 1'b0, 1'b0));
    for (int n = 0; n < 40; n++)
      send_item(mk(OP_STAMP, cur_t + TIME_BITS'(n), 32'sd3, 1'b1, 1'b0));
    send_item(mk(OP_STAMP, cur_t + 48'd70000, 32'sd3, 1'b1, 1'b1));

    in_valid <= 1'b0;
    @(posedge clk);
    waited = 0;
    while (pending != 0 && waited < 100000) begin
      @(posedge clk);
      waited++;
    end
    repeat (5) @(posedge clk);
    run_over <= 1'b1;
    @(posedge clk);
    @(posedge clk);

    $display("Run covered %0d input transfers under %0d register settings, %0d results checked.",
             sent_count, settings_count, checked);
    $display("Watchdog reports (first/silent/still/recovered/never): %0d, raster losses: %0d.",
             alerts, losses);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
